/* design/pbmhp_pkg.sv */
package pbmhp_pkg;

    // phase of the header walk
    typedef logic [4:0] t_phase;

    localparam t_phase PH_P      = 5'd0;
    localparam t_phase PH_FOUR   = 5'd1;
    localparam t_phase PH_MAGIC  = 5'd2;
    localparam t_phase PH_HEIGHT = 5'd13;
    localparam t_phase PH_DATA   = 5'd19;
    localparam t_phase PH_ERR    = 5'd20;

    // what a header phase does with a byte
    typedef enum logic [2:0] {
        K_NONE,
        K_CHECK,
        K_BODY,
        K_SPACE,
        K_DIGIT
    } t_kind;

    // status codes of a result
    typedef logic [1:0] t_status;

    localparam t_status ST_HDR  = 2'd0;
    localparam t_status ST_PIX  = 2'd1;
    localparam t_status ST_ERR  = 2'd2;
    localparam t_status ST_DONE = 2'd3;

    // header characters
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;

    localparam int OUT_DIM_BITS = 16;

    // phase to kind: comment slot, comment body, whitespace, number
    function automatic t_kind kind_of(input t_phase ph);
        t_kind k;
        case (ph)
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: k = K_CHECK;
            5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18: k = K_BODY;
            5'd4, 5'd10, 5'd16:                    k = K_SPACE;
            5'd7, 5'd13:                           k = K_DIGIT;
            default:                               k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_HT) && (b <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

/* design/pbmhp_if.sv */
interface pbmhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       is_last;

    modport source (output valid, output byte_in, output is_last, input ready);
    modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

interface pbmhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  pixel_byte;

    modport source (output valid, output status, output width, output height,
                    output pixel_byte, input ready);
    modport sink   (input valid, input status, input width, input height,
                    input pixel_byte, output ready);
endinterface

/* design/pbm_header_parser_top.sv */
// Binary PBM (P4) header parser with pixel pass-through. One file byte is
// taken per transfer and one result comes back per byte, in order: status
// (0 header byte, 1 pixel byte, 2 error, 3 header complete at file end),
// the width and height parsed so far (saturating at 2^DIM_BITS-1, low 16
// bits shown) and the pixel byte. The block sustains one byte per clock
// while the output is taken; a byte goes through an input register, the
// combinational phase update and an output register, and its result is
// offered once both registers hold it. The input register
// lets one more byte in while a result waits at the output. An error holds
// until the byte flagged last, after which the parser is back at reset for
// the next file.
module pbm_header_parser_top
    import pbmhp_pkg::*;
#(
    parameter int DIM_BITS   = 16,
    parameter int MAX_DIGITS = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pbmhp_in_if.sink      i_in,
    pbmhp_out_if.source   o_out
);

    localparam int ACC_BITS = DIM_BITS + 4;
    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
    localparam int STEPS = 6;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // parser state
    t_phase              r_phase;
    logic [3:0]          r_digit_count;
    logic [DIM_BITS-1:0] r_width;
    logic [DIM_BITS-1:0] r_height;

    // output register
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [OUT_DIM_BITS-1:0] r_out_width;
    logic [OUT_DIM_BITS-1:0] r_out_height;
    logic [7:0]              r_out_pixel;

    logic advance;
    logic take_in;

    // next state of the parser
    t_phase              n_phase;
    logic [3:0]          n_digit_count;
    logic [DIM_BITS-1:0] n_width;
    logic [DIM_BITS-1:0] n_height;
    t_status             n_status;

    assign advance  = !r_out_valid || o_out.ready;
    assign take_in  = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || advance;

    // walk the phases one byte at a time, chaining through skipped slots
    always_comb begin
        t_phase                ph;
        logic [3:0]            cnt;
        logic                  stop;
        t_status               res;
        logic                  acc_en;
        logic                  acc_h;
        logic [4:0]            cnt_inc;
        logic [DIM_BITS-1:0]   acc_src;
        logic [ACC_BITS-1:0]   prod;
        logic [DIM_BITS-1:0]   acc_new;
        logic                  done;
        logic [7:0]            b;

        b       = r_in_byte;
        ph      = r_phase;
        cnt     = r_digit_count;
        stop    = 1'b0;
        res     = ST_ERR;
        acc_en  = 1'b0;
        acc_h   = 1'b0;
        cnt_inc = '0;

        for (int s = 0; s < STEPS; s++) begin
            if (!stop) begin
                if (ph == PH_P) begin
                    ph   = (b == CH_P) ? PH_FOUR : PH_ERR;
                    res  = (b == CH_P) ? ST_HDR : ST_ERR;
                    stop = 1'b1;
                end else if (ph == PH_FOUR) begin
                    ph   = (b == CH_FOUR) ? PH_MAGIC : PH_ERR;
                    res  = (b == CH_FOUR) ? ST_HDR : ST_ERR;
                    stop = 1'b1;
                end else if (ph == PH_DATA) begin
                    res  = ST_PIX;
                    stop = 1'b1;
                end else if (ph >= PH_ERR) begin
                    ph   = PH_ERR;
                    res  = ST_ERR;
                    stop = 1'b1;
                end else begin
                    case (kind_of(ph))
                        K_CHECK: begin
                            if (b == CH_HASH) begin
                                ph   = ph + 5'd1;
                                res  = ST_HDR;
                                stop = 1'b1;
                            end else begin
                                ph = ph + 5'd2;
                            end
                        end
                        K_BODY: begin
                            if (b == CH_CR || b == CH_LF) begin
                                ph = ph + 5'd1;
                            end
                            res  = ST_HDR;
                            stop = 1'b1;
                        end
                        K_SPACE: begin
                            if (is_space(b)) begin
                                res  = ST_HDR;
                                stop = 1'b1;
                            end else begin
                                ph = ph + 5'd1;
                            end
                        end
                        K_DIGIT: begin
                            if (is_digit(b)) begin
                                acc_en  = 1'b1;
                                acc_h   = (ph == PH_HEIGHT);
                                cnt_inc = {1'b0, cnt} + 5'd1;
                                if (cnt_inc >= 5'(MAX_DIGITS)) begin
                                    cnt = '0;
                                    ph  = ph + 5'd1;
                                end else begin
                                    cnt = cnt_inc[3:0];
                                end
                                res  = ST_HDR;
                                stop = 1'b1;
                            end else if (cnt == '0) begin
                                ph   = PH_ERR;
                                res  = ST_ERR;
                                stop = 1'b1;
                            end else begin
                                cnt = '0;
                                ph  = ph + 5'd1;
                            end
                        end
                        default: begin
                            ph   = PH_ERR;
                            res  = ST_ERR;
                            stop = 1'b1;
                        end
                    endcase
                end
            end
        end

        if (!stop) begin
            ph  = PH_ERR;
            res = ST_ERR;
        end

        // multiply by ten and add the digit, saturating
        acc_src = acc_h ? r_height : r_width;
        prod    = {acc_src, 3'b000} + {2'b00, acc_src, 1'b0}
                + ACC_BITS'(4'(b - CH_ZERO));
        acc_new = (prod > {4'b0000, DIM_MAX}) ? DIM_MAX : prod[DIM_BITS-1:0];

        n_width  = (acc_en && !acc_h) ? acc_new : r_width;
        n_height = (acc_en && acc_h) ? acc_new : r_height;
        n_phase       = ph;
        n_digit_count = cnt;

        // status of the last byte of a file
        done     = (ph > PH_HEIGHT) || (ph == PH_HEIGHT && cnt != '0);
        n_status = res;
        if (r_in_last && res == ST_HDR) begin
            n_status = done ? ST_DONE : ST_ERR;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (take_in) begin
            r_in_byte <= i_in.byte_in;
            r_in_last <= i_in.is_last;
        end
    end

    // parser state, back to reset after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_P;
            r_digit_count <= '0;
            r_width       <= '0;
            r_height      <= '0;
        end else if (r_in_valid && advance) begin
            if (r_in_last) begin
                r_phase       <= PH_P;
                r_digit_count <= '0;
                r_width       <= '0;
                r_height      <= '0;
            end else begin
                r_phase       <= n_phase;
                r_digit_count <= n_digit_count;
                r_width       <= n_width;
                r_height      <= n_height;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out_status <= n_status;
            r_out_width  <= OUT_DIM_BITS'(n_width);
            r_out_height <= OUT_DIM_BITS'(n_height);
            r_out_pixel  <= (n_status == ST_PIX) ? r_in_byte : 8'h00;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.width      = r_out_width;
    assign o_out.height     = r_out_height;
    assign o_out.pixel_byte = r_out_pixel;

    // pixel byte is zero unless the result is a pixel transfer
    a_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_PIX) |-> (o_out.pixel_byte == 8'h00))
        else $error("pixel byte set on a non-pixel result");

    // the last byte of a file rearms the parser
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_last) |=>
            (r_phase == PH_P && r_digit_count == '0 && r_width == '0 && r_height == '0))
        else $error("parser not rearmed after last byte");

    // digit count stays below the number length limit
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_digit_count < 4'(MAX_DIGITS)))
        else $error("digit count reached its limit");

    // phase never leaves the defined range
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase <= PH_ERR))
        else $error("phase out of range");

    // pixel data only once the height has started
    a_pix_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && n_status == ST_PIX) |->
            (r_phase >= PH_HEIGHT && r_phase <= PH_DATA))
        else $error("pixel result before the height");

endmodule
